FILE: sv/jpds_pkg.sv
// Shared constants for the joint PD servo: register indexes, reset values,
// fault codes and field widths. No dependencies.
`timescale 1ns / 1ps
package jpds_pkg;

    localparam int JOINTS_DEF  = 4;
    localparam int TICK_HZ_DEF = 2000000;

    localparam int JIDX_W = 2;
    localparam int POS_W  = 32;
    localparam int TICK_W = 16;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 31;
    localparam int GAIN_W = 24;
    localparam int LIM_W  = 31;
    localparam int LAM_W  = 16;
    localparam int CODE_W = 2;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_KP          = 3'd0;
    localparam logic [CFG_AW-1:0] REG_KV          = 3'd1;
    localparam logic [CFG_AW-1:0] REG_ERR_LIMIT   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_ERR_CLAMP   = 3'd3;
    localparam logic [CFG_AW-1:0] REG_TRQ_CLAMP   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_TRQ_ABORT   = 3'd5;
    localparam logic [CFG_AW-1:0] REG_SPEED_LIMIT = 3'd6;
    localparam logic [CFG_AW-1:0] REG_LAMBDA      = 3'd7;

    localparam logic [GAIN_W-1:0] KP_RST  = 24'd218104;
    localparam logic [GAIN_W-1:0] KV_RST  = 24'd1678;
    localparam logic [LIM_W-1:0]  LIM_RST = 31'h7FFF_FFFF;
    localparam logic [LAM_W-1:0]  LAM_RST = 16'd123;

    // fault codes
    localparam logic [CODE_W-1:0] FLT_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] FLT_POSERR = 2'd1;
    localparam logic [CODE_W-1:0] FLT_SPEED  = 2'd2;
    localparam logic [CODE_W-1:0] FLT_TORQUE = 2'd3;

endpackage

FILE: sv/joint_pd_servo_with_safety_top.sv
// Joint PD servo with filtered speed estimate and latching safety monitor.
// Depends on jpds_pkg.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------------------
//  sample   | in        | i_in_valid / o_in_stall  | joint_index, target_pos,
//           |           |                          | measured_pos, elapsed_ticks
//  command  | out       | o_out_valid / i_out_stall| joint_out, torque_cmd,
//           |           |                          | filtered_speed, fault_code
//  config   | in        | i_cfg_wr_en              | i_cfg_addr, i_cfg_data
//
// Per sample, the speed divide runs two quotient bits per cycle through one
// 16-bit compare/subtract pair, and the remaining work is five passes
// through one shared signed multiplier plus setup/finish steps.
// Reset (synchronous, active low) clears the sequencer, per-joint positions
// and filtered speeds, the fault latch and loads the register defaults.
// o_in_stall is high while a sample is in flight. A finished command sits in
// the output register; the next sample can start meanwhile and only holds in
// its last step if the previous command has still not been taken.
`timescale 1ns / 1ps
module joint_pd_servo_with_safety_top #(
    parameter int JOINTS  = jpds_pkg::JOINTS_DEF,
    parameter int TICK_HZ = jpds_pkg::TICK_HZ_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_wr_en,
    input  logic [jpds_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  logic [jpds_pkg::CFG_DW-1:0]         i_cfg_data,
    // sample in
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [jpds_pkg::JIDX_W-1:0]         i_joint_index,
    input  logic signed [jpds_pkg::POS_W-1:0]   i_target_pos,
    input  logic signed [jpds_pkg::POS_W-1:0]   i_measured_pos,
    input  logic [jpds_pkg::TICK_W-1:0]         i_elapsed_ticks,
    // command out
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [jpds_pkg::JIDX_W-1:0]         o_joint_out,
    output logic signed [jpds_pkg::POS_W-1:0]   o_torque_cmd,
    output logic signed [jpds_pkg::POS_W-1:0]   o_filtered_speed,
    output logic [jpds_pkg::CODE_W-1:0]         o_fault_code
);
    import jpds_pkg::*;

    localparam int JW  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int TW  = $clog2(TICK_HZ + 1);
    localparam int MA  = POS_W + 1;                    // signed A operand
    localparam int MB  = (TW + 1 > GAIN_W + 1) ? TW + 1 : GAIN_W + 1;
    localparam int PW  = MA + MB;                      // product width
    localparam int AW  = PW + 1;                       // accumulator width
    localparam int DVW = PW + (PW % 2);                // dividend, even
    localparam int DIV_STEPS = DVW / 2;
    localparam int CW  = $clog2(DIV_STEPS + 1);
    localparam int TQW = POS_W + 2;                    // torque before clamp

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DELTA = 13'b0000000000010,
        S_DABS  = 13'b0000000000100,
        S_DIV   = 13'b0000000001000,
        S_SAT   = 13'b0000000010000,
        S_M1    = 13'b0000000100000,
        S_M2    = 13'b0000001000000,
        S_M3    = 13'b0000010000000,
        S_SPD   = 13'b0000100000000,
        S_K1    = 13'b0001000000000,
        S_K2    = 13'b0010000000000,
        S_K3    = 13'b0100000000000,
        S_TQ    = 13'b1000000000000
    } t_state;

    // fold a joint index into the state range with a few compare/subtracts
    function automatic logic [JW-1:0] f_fold(input logic [JIDX_W-1:0] v);
        logic [4:0] x;
        x = 5'(v);
        for (int k = 0; k < 3; k++) begin
            if (x >= 5'(JOINTS)) x = x - 5'(JOINTS);
        end
        return x[JW-1:0];
    endfunction

    // configuration registers
    logic [GAIN_W-1:0] r_kp, r_kv;
    logic [LIM_W-1:0]  r_err_lim, r_err_clamp, r_trq_clamp, r_trq_abort, r_spd_lim;
    logic [LAM_W-1:0]  r_lam;

    // per-joint state
    logic signed [POS_W-1:0] r_last  [JOINTS];
    logic signed [POS_W-1:0] r_smooth[JOINTS];
    logic [CODE_W-1:0]       r_fault;

    // sequencer and datapath
    t_state                  r_state;
    logic [CW-1:0]           r_cnt;
    logic [JIDX_W-1:0]       r_jin;
    logic [JW-1:0]           r_j;
    logic signed [POS_W-1:0] r_target, r_meas;
    logic [TICK_W-1:0]       r_den;
    logic signed [PW-1:0]    r_p;
    logic signed [AW-1:0]    r_acc;
    logic [DVW-1:0]          r_dvd;
    logic [TICK_W-1:0]       r_rem;
    logic                    r_neg;
    logic signed [POS_W-1:0] r_raw, r_speed, r_err_c;
    logic [CODE_W-1:0]       r_code;

    // output register
    logic                    r_out_valid;
    logic [JIDX_W-1:0]       r_o_joint;
    logic signed [POS_W-1:0] r_o_torque, r_o_speed;
    logic [CODE_W-1:0]       r_o_code;

    // shared multiplier
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic [LAM_W:0]       w_new;

    always_comb begin
        w_new = 17'h10000 - {1'b0, r_lam};
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DELTA: begin
                mul_a = MA'(r_meas) - MA'(r_last[r_j]);
                mul_b = MB'(TICK_HZ);
            end
            S_M1: begin
                mul_a = MA'(r_raw);
                mul_b = MB'(w_new);
            end
            S_M2: begin
                mul_a = MA'(r_smooth[r_j]);
                mul_b = MB'(r_lam);
            end
            S_K1: begin
                mul_a = MA'(r_err_c);
                mul_b = MB'(r_kp);
            end
            S_K2: begin
                mul_a = MA'(r_speed);
                mul_b = MB'(r_kv);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = PW'(mul_a) * PW'(mul_b);
    end

    // divider: two restoring steps per cycle
    logic [TICK_W:0]   rem_a, rem_b;
    logic [TICK_W-1:0] rem1, rem2;
    logic              q1, q2;
    always_comb begin
        rem_a = {r_rem, r_dvd[DVW-1]};
        q1    = (rem_a >= {1'b0, r_den});
        rem1  = q1 ? TICK_W'(rem_a - {1'b0, r_den}) : rem_a[TICK_W-1:0];
        rem_b = {rem1, r_dvd[DVW-2]};
        q2    = (rem_b >= {1'b0, r_den});
        rem2  = q2 ? TICK_W'(rem_b - {1'b0, r_den}) : rem_b[TICK_W-1:0];
    end

    // magnitude of the scaled position change
    logic signed [PW-1:0] p_mag;
    assign p_mag = r_p[PW-1] ? -r_p : r_p;

    // quotient to saturated raw speed
    logic                    ovf_pos, ovf_neg;
    logic signed [POS_W-1:0] raw_sat;
    always_comb begin
        ovf_pos = |r_dvd[DVW-1:31];
        ovf_neg = (|r_dvd[DVW-1:32]) || (r_dvd[31] && (|r_dvd[30:0]));
        if (r_neg) begin
            raw_sat = ovf_neg ? 32'sh8000_0000 : -$signed(r_dvd[31:0]);
        end else begin
            raw_sat = ovf_pos ? 32'sh7FFF_FFFF : $signed(r_dvd[31:0]);
        end
    end

    // filtered speed, error checks
    logic signed [AW-1:0]    acc_spd;
    logic signed [POS_W-1:0] speed;
    logic signed [POS_W:0]   err, err_cl, ec;
    logic [POS_W:0]          err_mag, spd_mag, spd_lim;
    logic [CODE_W-1:0]       code_spd;
    always_comb begin
        acc_spd = r_acc + (r_acc[AW-1] ? AW'(65535) : AW'(0));
        speed   = acc_spd[47:16];
        err     = (POS_W+1)'(r_target) - (POS_W+1)'(r_meas);
        err_mag = err[POS_W] ? unsigned'(-err) : unsigned'(err);
        ec      = signed'({2'b0, r_err_clamp});
        if (err > ec) begin
            err_cl = ec;
        end else if (err < -ec) begin
            err_cl = -ec;
        end else begin
            err_cl = err;
        end
        spd_mag = speed[POS_W-1] ? unsigned'(-(POS_W+1)'(speed))
                                 : unsigned'((POS_W+1)'(speed));
        spd_lim = (r_j != '0) ? {1'b0, r_spd_lim, 1'b0} : {2'b0, r_spd_lim};
        if (err_mag > {2'b0, r_err_lim}) begin
            code_spd = FLT_POSERR;
        end else if (spd_mag > spd_lim) begin
            code_spd = FLT_SPEED;
        end else begin
            code_spd = FLT_NONE;
        end
    end

    // torque finish
    logic signed [AW-1:0]    acc_tq;
    logic signed [TQW-1:0]   tq, tc;
    logic [TQW-1:0]          tq_mag;
    logic signed [POS_W-1:0] tq_cl;
    logic [CODE_W-1:0]       code_all, fault_nxt;
    always_comb begin
        acc_tq = r_acc + (r_acc[AW-1] ? AW'(24'hFF_FFFF) : AW'(0));
        tq     = acc_tq[24 +: TQW];
        tq_mag = tq[TQW-1] ? unsigned'(-tq) : unsigned'(tq);
        tc     = signed'({3'b0, r_trq_clamp});
        if (tq > tc) begin
            tq_cl = POS_W'(tc);
        end else if (tq < -tc) begin
            tq_cl = POS_W'(-tc);
        end else begin
            tq_cl = POS_W'(tq);
        end
        if (r_code != FLT_NONE) begin
            code_all = r_code;
        end else if (tq_mag > {3'b0, r_trq_abort}) begin
            code_all = FLT_TORQUE;
        end else begin
            code_all = FLT_NONE;
        end
        fault_nxt = (r_fault == FLT_NONE) ? code_all : r_fault;
    end

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp        <= KP_RST;
            r_kv        <= KV_RST;
            r_err_lim   <= LIM_RST;
            r_err_clamp <= LIM_RST;
            r_trq_clamp <= LIM_RST;
            r_trq_abort <= LIM_RST;
            r_spd_lim   <= LIM_RST;
            r_lam       <= LAM_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_KP:          r_kp        <= i_cfg_data[GAIN_W-1:0];
                REG_KV:          r_kv        <= i_cfg_data[GAIN_W-1:0];
                REG_ERR_LIMIT:   r_err_lim   <= i_cfg_data;
                REG_ERR_CLAMP:   r_err_clamp <= i_cfg_data;
                REG_TRQ_CLAMP:   r_trq_clamp <= i_cfg_data;
                REG_TRQ_ABORT:   r_trq_abort <= i_cfg_data;
                REG_SPEED_LIMIT: r_spd_lim   <= i_cfg_data;
                REG_LAMBDA:      r_lam       <= i_cfg_data[LAM_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_fault     <= FLT_NONE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < JOINTS; k++) begin
                r_last[k]   <= '0;
                r_smooth[k] <= '0;
            end
        end else begin
            // in S_TQ the handoff below decides the output valid
            if (r_out_valid && !i_out_stall && r_state != S_TQ) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_DELTA;
                S_DELTA: r_state <= S_DABS;
                S_DABS: begin
                    r_cnt   <= CW'(DIV_STEPS);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CW'(1)) r_state <= S_SAT;
                end
                S_SAT: r_state <= S_M1;
                S_M1:  r_state <= S_M2;
                S_M2:  r_state <= S_M3;
                S_M3:  r_state <= S_SPD;
                S_SPD: begin
                    r_smooth[r_j] <= speed;
                    r_last[r_j]   <= r_meas;
                    r_state       <= S_K1;
                end
                S_K1: r_state <= S_K2;
                S_K2: r_state <= S_K3;
                S_K3: r_state <= S_TQ;
                S_TQ: begin
                    if (out_free) begin
                        r_fault     <= fault_nxt;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_jin    <= i_joint_index;
                r_j      <= f_fold(i_joint_index);
                r_target <= i_target_pos;
                r_meas   <= i_measured_pos;
                r_den    <= (i_elapsed_ticks == '0) ? TICK_W'(1) : i_elapsed_ticks;
            end
            S_DELTA: r_p <= prod;
            S_DABS: begin
                r_dvd <= DVW'(unsigned'(p_mag));
                r_neg <= r_p[PW-1];
                r_rem <= '0;
            end
            S_DIV: begin
                r_dvd <= {r_dvd[DVW-3:0], q1, q2};
                r_rem <= rem2;
            end
            S_SAT: r_raw <= raw_sat;
            S_M1:  r_p <= prod;
            S_M2: begin
                r_acc <= AW'(r_p);
                r_p   <= prod;
            end
            S_M3: r_acc <= r_acc + AW'(r_p);
            S_SPD: begin
                r_speed <= speed;
                r_err_c <= POS_W'(err_cl);
                r_code  <= code_spd;
            end
            S_K1: r_p <= prod;
            S_K2: begin
                r_acc <= AW'(r_p);
                r_p   <= prod;
            end
            S_K3: r_acc <= r_acc - AW'(r_p);
            S_TQ: begin
                if (out_free) begin
                    r_o_joint  <= r_jin;
                    r_o_torque <= (fault_nxt != FLT_NONE) ? '0 : tq_cl;
                    r_o_speed  <= r_speed;
                    r_o_code   <= fault_nxt;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_joint_out      = r_o_joint;
    assign o_torque_cmd     = r_o_torque;
    assign o_filtered_speed = r_o_speed;
    assign o_fault_code     = r_o_code;

endmodule
